// ===== rtl/bitmap_page_allocator_assert.svh =====
// Assertion macros shared by the checker.
// Each one samples on the rising edge of clk and is off while rst_n is low.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BPA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap page allocator check failed");

// Next-cycle implication.
`define BPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap page allocator check failed");

`endif

// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 17;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_ALLOC   = 2'd0;
    localparam mode_t MODE_RELEASE = 2'd1;
    localparam mode_t MODE_RESERVE = 2'd2;

    typedef struct packed {
        mode_t             mode;
        logic [PAGE_W-1:0] page_number;
    } bpa_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  result_page;
        logic               ok;
        logic [COUNT_W-1:0] free_pages;
    } bpa_rsp_t;

    // Index of the lowest clear bit; zero when the byte is full.
    function automatic logic [2:0] lowest_clear(input logic [BYTE_W-1:0] b);
        logic [2:0] k;
        logic       hit;
        k   = 3'd0;
        hit = 1'b0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (!hit && !b[i])
            begin
                k   = 3'(i);
                hit = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/bpa_stream_if.sv =====
`timescale 1ns / 1ps

interface bpa_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bitmap_page_allocator.sv =====
`timescale 1ns / 1ps

// Bitmap page frame allocator, next-fit. One bit per page in a byte-wide RAM
// (1 = used). After reset a clearing pass writes 0xFF to every byte, one byte
// per cycle, so the block takes no request until the pass is done; software
// then frees usable pages with release requests. Each request word gives
// exactly one response word. Allocate scans bytes from the hint byte, one RAM
// read per cycle, wraps at the top and stops before the hint, reading 1 up to
// NUM_PAGES/8 bytes (rounded up); on a byte with a clear bit, or when the store
// is full, it holds until the response slot is free. Release and reserve do one
// read-modify-write; an out-of-range page or unused mode fails with no RAM
// write. The scan through the single RAM read port sets the allocate time.
// The response sits in an output register, so a new request is taken while
// the previous response waits; the next response stalls until it is taken.
// The free count is 17 bits and changes only when a bit really flips.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    bpa_stream_if.sink        req,
    bpa_stream_if.source      rsp
);

    localparam int NUM_BYTES = (NUM_PAGES + 7) / 8;
    localparam int AW        = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam logic [AW-1:0] LAST_BYTE = AW'(NUM_BYTES - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_REPLY  = 3'd4;

    // Control state
    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      cur_reg, cur_next;      // byte under work / clear pointer
    logic [AW-1:0]      remain_reg, remain_next; // bytes left to scan
    logic [AW-1:0]      hint_reg, hint_next;
    logic [COUNT_W-1:0] free_reg, free_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Payload
    mode_t              mode_reg, mode_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [PAGE_W-1:0]  rsp_page_reg, rsp_page_next;
    logic               rsp_ok_reg, rsp_ok_next;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               out_free;
    logic               req_fire;
    logic               in_range;
    logic [AW-1:0]      req_idx;
    logic [AW-1:0]      cur_wrap;
    logic [2:0]         free_bit;
    logic [BYTE_W-1:0]  page_mask;
    logic               page_used;
    bpa_rsp_t           rsp_word;

    bpa_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NUM_BYTES)
    ) u_bpa_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign in_range  = {16'd0, req.data.page_number} < 32'(NUM_PAGES);
    assign req_idx   = AW'(req.data.page_number[PAGE_W-1:3]);
    assign cur_wrap  = (cur_reg == LAST_BYTE) ? '0 : cur_reg + AW'(1);
    assign free_bit  = lowest_clear(ram_rdata);
    assign page_mask = 8'b1 << page_reg[2:0];
    assign page_used = (ram_rdata & page_mask) != '0;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        remain_next    = remain_reg;
        hint_next      = hint_reg;
        free_next      = free_reg;
        rsp_valid_next = rsp_valid_reg;
        mode_next      = mode_reg;
        page_next      = page_reg;
        rsp_page_next  = rsp_page_reg;
        rsp_ok_next    = rsp_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = BYTE_FULL;
        ram_raddr      = cur_reg;

        // Response taken, slot empties unless refilled below.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cur_next = cur_reg + AW'(1);
                if (cur_reg == LAST_BYTE)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                ram_raddr = (req.data.mode == MODE_ALLOC) ? hint_reg : req_idx;
                if (req_fire)
                begin
                    mode_next = req.data.mode;
                    page_next = req.data.page_number;
                    case (req.data.mode)
                        MODE_ALLOC:
                        begin
                            cur_next    = hint_reg;
                            remain_next = LAST_BYTE;
                            state_next  = ST_SCAN;
                        end
                        MODE_RELEASE, MODE_RESERVE:
                        begin
                            cur_next   = req_idx;
                            state_next = in_range ? ST_MODIFY : ST_REPLY;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (ram_rdata != BYTE_FULL)
                begin
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata | (8'b1 << free_bit);
                        free_next      = free_reg - COUNT_W'(1);
                        hint_next      = cur_reg;
                        rsp_page_next  = PAGE_W'({cur_reg, free_bit});
                        rsp_ok_next    = 1'b1;
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (remain_reg == '0)
                begin
                    // Wrapped back to the hint: store is full.
                    if (out_free)
                    begin
                        rsp_page_next  = '0;
                        rsp_ok_next    = 1'b0;
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    ram_raddr   = cur_wrap;
                    cur_next    = cur_wrap;
                    remain_next = remain_reg - AW'(1);
                end
            end

            ST_MODIFY:
            begin
                if (out_free)
                begin
                    if (mode_reg == MODE_RELEASE && page_used)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~page_mask;
                        free_next = free_reg + COUNT_W'(1);
                    end
                    else if (mode_reg == MODE_RESERVE && !page_used)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | page_mask;
                        free_next = free_reg - COUNT_W'(1);
                    end
                    rsp_page_next  = page_reg;
                    rsp_ok_next    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_REPLY:
            begin
                // Out-of-range page or unused mode: echo, fail, no change.
                if (out_free)
                begin
                    rsp_page_next  = page_reg;
                    rsp_ok_next    = 1'b0;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            remain_reg    <= '0;
            hint_reg      <= '0;
            free_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            remain_reg    <= remain_next;
            hint_reg      <= hint_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        page_reg     <= page_next;
        rsp_page_reg <= rsp_page_next;
        rsp_ok_reg   <= rsp_ok_next;
    end

    always_comb
    begin
        rsp_word.result_page = rsp_page_reg;
        rsp_word.ok          = rsp_ok_reg;
        rsp_word.free_pages  = free_reg;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word;

endmodule

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bpa_checker.sv =====
`timescale 1ns / 1ps
`include "bitmap_page_allocator_assert.svh"

module bpa_checker
    import bpa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input bpa_rsp_t rsp_data
);

    logic [COUNT_W-1:0] last_free_reg, last_free_next;
    logic               rsp_fire;
    logic               req_fire;

    assign rsp_fire       = rsp_valid && rsp_ready;
    assign req_fire       = req_valid && req_ready;
    assign last_free_next = rsp_fire ? rsp_data.free_pages : last_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_free_reg <= '0;
        end
        else
        begin
            last_free_reg <= last_free_next;
        end
    end

    // Stalled response word holds.
    `BPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

    // One request at a time.
    `BPA_ASSERT_NEXT(a_one_at_a_time, req_fire, !req_ready)

    // Count moves by at most one page per word.
    `BPA_ASSERT_IMPL(a_count_step, rsp_fire,
        rsp_data.free_pages == last_free_reg ||
        rsp_data.free_pages == last_free_reg + COUNT_W'(1) ||
        rsp_data.free_pages == last_free_reg - COUNT_W'(1))

    // A failed request changes nothing.
    `BPA_ASSERT_IMPL(a_fail_no_change, rsp_fire && !rsp_data.ok,
        rsp_data.free_pages == last_free_reg)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
